[hdl/assert_macros.svh]
// assertion macros shared by the hamming nearest-template rtl
// no dependencies; concurrent forms in simulation, empty bodies in synthesis
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property checked at every rising edge outside reset
`define HNT_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("hnt assertion failed");

// antecedent implies consequent in the same cycle
`define HNT_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  `HNT_ASSERT(lbl, clk, rst_n, (ante) |-> (cons))

// antecedent implies consequent in the next cycle
`define HNT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  `HNT_ASSERT(lbl, clk, rst_n, (ante) |=> (cons))

`else

`define HNT_ASSERT(lbl, clk, rst_n, prop)
`define HNT_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define HNT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

[hdl/hnt_pkg.sv]
// shared types, constants and helpers of the hamming nearest-template block
// no dependencies
package hnt_pkg;

  // default configuration of the block
  localparam int DEF_MAX_TEMPLATES  = 256;
  localparam int DEF_GRID_WIDTH     = 32;
  localparam int DEF_GRID_HEIGHT    = 32;
  localparam int DEF_CELLS_PER_WORD = 32;

  // fixed field widths
  localparam int WORD_W     = 32;
  localparam int WIDX_W     = 5;
  localparam int TIDX_W     = 8;
  localparam int CNT_W      = 9;
  localparam int DIST_W     = 11;
  localparam int PC_W       = 6;
  localparam int SLOT_WORDS = 32;

  // operation codes on the mode field
  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  // search sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_DRAIN
  } state_t;

  // tags travelling with one word through the distance pipeline
  typedef struct packed {
    logic valid;
    logic first_word;
    logic last_word;
  } pipe_ctrl_t;

  // status of the distance unit towards the sequencer
  typedef struct packed {
    logic busy;
    logic found;
  } dist_status_t;

  // ones count of a 32-bit word as a five-level adder tree
  function automatic logic [PC_W-1:0] popcount32(input logic [WORD_W-1:0] v);
    logic [1:0] l1 [16];
    logic [2:0] l2 [8];
    logic [3:0] l3 [4];
    logic [4:0] l4 [2];
    for (int i = 0; i < 16; i++) begin
      l1[i] = {1'b0, v[2*i]} + {1'b0, v[2*i+1]};
    end
    for (int i = 0; i < 8; i++) begin
      l2[i] = {1'b0, l1[2*i]} + {1'b0, l1[2*i+1]};
    end
    for (int i = 0; i < 4; i++) begin
      l3[i] = {1'b0, l2[2*i]} + {1'b0, l2[2*i+1]};
    end
    for (int i = 0; i < 2; i++) begin
      l4[i] = {1'b0, l3[2*i]} + {1'b0, l3[2*i+1]};
    end
    return {1'b0, l4[0]} + {1'b0, l4[1]};
  endfunction

endpackage

[hdl/hnt_ram.sv]
// single-port-write, single-port-read ram with registered read data
// depends on nothing; used for the template store and the query buffer
module hnt_ram #(
  parameter int DEPTH  = 32,
  parameter int ADDR_W = 5,
  parameter int DATA_W = 32
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[hdl/hnt_dist_unit.sv]
// shared popcount, accumulate and compare unit of the nearest-template search
// depends on hnt_pkg and assert_macros.svh
`include "assert_macros.svh"

module hnt_dist_unit #(
  parameter int TI_W     = 8,
  parameter int MAX_DIST = 1024
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        clear,
  input  hnt_pkg::pipe_ctrl_t         ctrl,
  input  logic [TI_W-1:0]             tidx,
  input  logic [hnt_pkg::WORD_W-1:0]  query_word,
  input  logic [hnt_pkg::WORD_W-1:0]  tmpl_word,
  input  logic [hnt_pkg::WORD_W-1:0]  mask,
  output hnt_pkg::dist_status_t       status,
  output logic [TI_W-1:0]             win_idx,
  output logic [hnt_pkg::DIST_W-1:0]  win_dist
);

  hnt_pkg::pipe_ctrl_t          s2_r;
  logic [TI_W-1:0]              s2_tidx_r;
  logic [hnt_pkg::PC_W-1:0]     pc_r;
  logic [hnt_pkg::DIST_W-1:0]   acc_r;
  logic [hnt_pkg::DIST_W-1:0]   acc_nxt;
  logic                         found_r;
  logic                         found_nxt;
  logic [TI_W-1:0]              win_idx_r;
  logic [TI_W-1:0]              win_idx_nxt;
  logic [hnt_pkg::DIST_W-1:0]   win_dist_r;
  logic [hnt_pkg::DIST_W-1:0]   win_dist_nxt;

  // stage two: masked difference count of one word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_r <= '0;
    end else begin
      s2_r <= ctrl;
    end
  end

  always_ff @(posedge clk) begin
    pc_r      <= hnt_pkg::popcount32((query_word ^ tmpl_word) & mask);
    s2_tidx_r <= tidx;
  end

  // stage three: per-template sum and running minimum, first strict winner kept
  always_comb begin
    acc_nxt      = acc_r;
    found_nxt    = found_r;
    win_idx_nxt  = win_idx_r;
    win_dist_nxt = win_dist_r;
    if (clear) begin
      found_nxt    = 1'b0;
      win_idx_nxt  = '0;
      win_dist_nxt = '0;
    end else if (s2_r.valid) begin
      acc_nxt = (s2_r.first_word ? '0 : acc_r) + hnt_pkg::DIST_W'(pc_r);
      if (s2_r.last_word && (!found_r || acc_nxt < win_dist_r)) begin
        found_nxt    = 1'b1;
        win_idx_nxt  = s2_tidx_r;
        win_dist_nxt = acc_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
    end else begin
      found_r <= found_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r      <= acc_nxt;
    win_idx_r  <= win_idx_nxt;
    win_dist_r <= win_dist_nxt;
  end

  assign status.busy  = ctrl.valid | s2_r.valid;
  assign status.found = found_r;
  assign win_idx      = win_idx_r;
  assign win_dist     = win_dist_r;

  // a distance never exceeds the cells of one mask, so no saturation is needed
  `HNT_ASSERT_IMPL(a_dist_bound, clk, rst_n, found_r,
                   win_dist_r <= hnt_pkg::DIST_W'(MAX_DIST))
  // a cleared search reports zero index and distance until a template wins
  `HNT_ASSERT_NEXT(a_clear_zero, clk, rst_n, clear,
                   !found_r && win_idx_r == '0 && win_dist_r == '0)

endmodule

[hdl/hamming_nearest_template.sv]
// nearest-template classifier over packed binary masks, top level and sequencer
// depends on hnt_pkg, hnt_ram, hnt_dist_unit and assert_macros.svh
//
// input: one transaction when start is high and busy is low. mode 0 writes
// in_word_bits to word in_word_index of template in_template_index. mode 1
// writes a query word; with in_last set it also starts the search.
// loads and query words without in_last leave busy low.
// search: templates 0 .. template_count-1 (saturated to MAX_TEMPLATES) are
// walked word by word through one shared popcount and compare unit, one
// template word per cycle, set by the single store read port. busy is high
// for the whole search.
// result: out_valid pulses for one cycle with match_found, best_index and
// best_distance; the receiver cannot stall and must take it then.
// config: cfg_template_count is written when cfg_valid and cfg_ready are high;
// cfg_ready is low during a search.
// reset: template_count clears to zero and the sequencer goes idle. the stores
// are not cleared; their contents are undefined until written.
`include "assert_macros.svh"

module hamming_nearest_template #(
  parameter int MAX_TEMPLATES  = hnt_pkg::DEF_MAX_TEMPLATES,
  parameter int GRID_WIDTH     = hnt_pkg::DEF_GRID_WIDTH,
  parameter int GRID_HEIGHT    = hnt_pkg::DEF_GRID_HEIGHT,
  parameter int CELLS_PER_WORD = hnt_pkg::DEF_CELLS_PER_WORD
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // input channel
  input  logic                        start,
  output logic                        busy,
  input  logic                        in_mode,
  input  logic [hnt_pkg::TIDX_W-1:0]  in_template_index,
  input  logic [hnt_pkg::WIDX_W-1:0]  in_word_index,
  input  logic [hnt_pkg::WORD_W-1:0]  in_word_bits,
  input  logic                        in_last,
  // result channel
  output logic                        out_valid,
  output logic                        out_match_found,
  output logic [hnt_pkg::TIDX_W-1:0]  out_best_index,
  output logic [hnt_pkg::DIST_W-1:0]  out_best_distance,
  // configuration channel
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [hnt_pkg::CNT_W-1:0]   cfg_template_count
);

  localparam int TOTAL_CELLS   = GRID_WIDTH * GRID_HEIGHT;
  localparam int WORDS_NEEDED  = (TOTAL_CELLS + CELLS_PER_WORD - 1) / CELLS_PER_WORD;
  localparam int MASK_WORDS    = (WORDS_NEEDED < hnt_pkg::SLOT_WORDS) ?
                                 WORDS_NEEDED : hnt_pkg::SLOT_WORDS;
  localparam int BITS_PER_SLOT = (CELLS_PER_WORD < hnt_pkg::WORD_W) ?
                                 CELLS_PER_WORD : hnt_pkg::WORD_W;
  localparam int MAX_DIST      = MASK_WORDS * BITS_PER_SLOT;
  localparam int TI_W          = (MAX_TEMPLATES > 1) ? $clog2(MAX_TEMPLATES) : 1;
  localparam int TC_W          = $clog2(MAX_TEMPLATES + 1);
  localparam int CMP_A         = (TC_W > hnt_pkg::CNT_W) ? TC_W : hnt_pkg::CNT_W;
  localparam int CMP_W         = (CMP_A > hnt_pkg::TIDX_W + 1) ? CMP_A : hnt_pkg::TIDX_W + 1;
  localparam int TA_W          = TI_W + hnt_pkg::WIDX_W;
  localparam int T_DEPTH       = MAX_TEMPLATES * hnt_pkg::SLOT_WORDS;

  // cells of word w that lie inside the grid
  function automatic logic [hnt_pkg::WORD_W-1:0] word_valid_mask(
    input logic [hnt_pkg::WIDX_W-1:0] w
  );
    int start_cell;
    int left;
    logic [hnt_pkg::WORD_W-1:0] m;
    start_cell = int'(w) * CELLS_PER_WORD;
    if (start_cell >= TOTAL_CELLS) begin
      m = '0;
    end else begin
      left = TOTAL_CELLS - start_cell;
      if (left > BITS_PER_SLOT) begin
        left = BITS_PER_SLOT;
      end
      if (left >= hnt_pkg::WORD_W) begin
        m = '1;
      end else begin
        m = (hnt_pkg::WORD_W'(1) << left) - hnt_pkg::WORD_W'(1);
      end
    end
    return m;
  endfunction

  hnt_pkg::state_t              state_r;
  hnt_pkg::state_t              state_nxt;
  logic [hnt_pkg::CNT_W-1:0]    template_count_r;
  logic [TC_W-1:0]              count_r;
  logic [TC_W-1:0]              count_nxt;
  logic [TC_W-1:0]              count_sat;
  logic [TI_W-1:0]              t_r;
  logic [TI_W-1:0]              t_nxt;
  logic [hnt_pkg::WIDX_W-1:0]   w_r;
  logic [hnt_pkg::WIDX_W-1:0]   w_nxt;
  logic                         w_last;
  logic                         t_last;
  logic                         issue;
  logic                         clear;
  logic                         emit;
  logic                         accept;
  logic                         word_in_range;
  logic                         slot_in_range;
  logic                         q_we;
  logic                         t_we;
  logic [TA_W-1:0]              t_waddr;
  logic [hnt_pkg::WORD_W-1:0]   q_rdata;
  logic [hnt_pkg::WORD_W-1:0]   t_rdata;
  hnt_pkg::pipe_ctrl_t          s1_r;
  logic [TI_W-1:0]              s1_tidx_r;
  logic [hnt_pkg::WORD_W-1:0]   s1_mask_r;
  hnt_pkg::dist_status_t        dstat;
  logic [TI_W-1:0]              win_idx;
  logic [hnt_pkg::DIST_W-1:0]   win_dist;
  logic                         out_valid_r;
  logic                         out_match_found_r;
  logic [hnt_pkg::TIDX_W-1:0]   out_best_index_r;
  logic [hnt_pkg::DIST_W-1:0]   out_best_distance_r;

  // handshakes
  assign busy      = (state_r != hnt_pkg::S_IDLE);
  assign accept    = start && !busy;
  assign cfg_ready = !busy;

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      template_count_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      template_count_r <= cfg_template_count;
    end
  end

  // write side of both stores
  assign word_in_range = (6'(in_word_index) < 6'(MASK_WORDS));
  assign slot_in_range = (CMP_W'(in_template_index) < CMP_W'(MAX_TEMPLATES));
  assign q_we          = accept && (in_mode == hnt_pkg::MODE_QUERY) && word_in_range;
  assign t_we          = accept && (in_mode == hnt_pkg::MODE_LOAD) && word_in_range &&
                         slot_in_range;
  assign t_waddr       = {TI_W'(in_template_index), in_word_index};

  hnt_ram #(
    .DEPTH  (hnt_pkg::SLOT_WORDS),
    .ADDR_W (hnt_pkg::WIDX_W),
    .DATA_W (hnt_pkg::WORD_W)
  ) u_query_buf (
    .clk   (clk),
    .we    (q_we),
    .waddr (in_word_index),
    .wdata (in_word_bits),
    .raddr (w_r),
    .rdata (q_rdata)
  );

  hnt_ram #(
    .DEPTH  (T_DEPTH),
    .ADDR_W (TA_W),
    .DATA_W (hnt_pkg::WORD_W)
  ) u_tmpl_store (
    .clk   (clk),
    .we    (t_we),
    .waddr (t_waddr),
    .wdata (in_word_bits),
    .raddr ({t_r, w_r}),
    .rdata (t_rdata)
  );

  // search length, saturated to the store size
  always_comb begin
    if (CMP_W'(template_count_r) > CMP_W'(MAX_TEMPLATES)) begin
      count_sat = TC_W'(MAX_TEMPLATES);
    end else begin
      count_sat = TC_W'(template_count_r);
    end
  end

  assign w_last = (w_r == hnt_pkg::WIDX_W'(MASK_WORDS - 1));
  assign t_last = ((TC_W'(t_r) + TC_W'(1)) == count_r);

  // sequencer state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= hnt_pkg::S_IDLE;
      count_r <= '0;
      t_r     <= '0;
      w_r     <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      t_r     <= t_nxt;
      w_r     <= w_nxt;
    end
  end

  // sequencer next state: walk templates, then wait for the pipeline to empty
  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    t_nxt     = t_r;
    w_nxt     = w_r;
    issue     = 1'b0;
    clear     = 1'b0;
    emit      = 1'b0;
    case (state_r)
      hnt_pkg::S_IDLE: begin
        if (accept && (in_mode == hnt_pkg::MODE_QUERY) && in_last) begin
          clear     = 1'b1;
          count_nxt = count_sat;
          t_nxt     = '0;
          w_nxt     = '0;
          state_nxt = (count_sat == '0) ? hnt_pkg::S_DRAIN : hnt_pkg::S_RUN;
        end
      end
      hnt_pkg::S_RUN: begin
        issue = 1'b1;
        if (w_last) begin
          w_nxt = '0;
          if (t_last) begin
            state_nxt = hnt_pkg::S_DRAIN;
          end else begin
            t_nxt = t_r + TI_W'(1);
          end
        end else begin
          w_nxt = w_r + hnt_pkg::WIDX_W'(1);
        end
      end
      hnt_pkg::S_DRAIN: begin
        if (!dstat.busy) begin
          emit      = 1'b1;
          state_nxt = hnt_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = hnt_pkg::S_IDLE;
      end
    endcase
  end

  // stage one: tags line up with the registered store read data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r <= '0;
    end else begin
      s1_r.valid      <= issue;
      s1_r.first_word <= (w_r == '0);
      s1_r.last_word  <= w_last;
    end
  end

  always_ff @(posedge clk) begin
    s1_tidx_r <= t_r;
    s1_mask_r <= word_valid_mask(w_r);
  end

  hnt_dist_unit #(
    .TI_W     (TI_W),
    .MAX_DIST (MAX_DIST)
  ) u_dist (
    .clk        (clk),
    .rst_n      (rst_n),
    .clear      (clear),
    .ctrl       (s1_r),
    .tidx       (s1_tidx_r),
    .query_word (q_rdata),
    .tmpl_word  (t_rdata),
    .mask       (s1_mask_r),
    .status     (dstat),
    .win_idx    (win_idx),
    .win_dist   (win_dist)
  );

  // result register, one-cycle strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_match_found_r   <= dstat.found;
      out_best_index_r    <= hnt_pkg::TIDX_W'(win_idx);
      out_best_distance_r <= win_dist;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_match_found   = out_match_found_r;
  assign out_best_index    = out_best_index_r;
  assign out_best_distance = out_best_distance_r;

  // a result only follows a drained search
  `HNT_ASSERT_IMPL(a_emit_after_drain, clk, rst_n, out_valid_r,
                   $past(state_r) == hnt_pkg::S_DRAIN)
  // a result transaction is never repeated in the following cycle
  `HNT_ASSERT_NEXT(a_single_strobe, clk, rst_n, out_valid_r, !out_valid_r)
  // store reads enter the pipeline only while templates are walked
  `HNT_ASSERT_IMPL(a_issue_in_run, clk, rst_n, s1_r.valid,
                   $past(state_r) == hnt_pkg::S_RUN)
  // no load or query word is taken while a search is under way
  `HNT_ASSERT_IMPL(a_no_write_busy, clk, rst_n, busy, !q_we && !t_we)

endmodule
